[hdl/fprc_pkg.sv]
// ----------------------------------------------------------------------------
// fprc_pkg
// Shared types and constants of the framed packet receiver with CRC-16 check.
// ----------------------------------------------------------------------------
package fprc_pkg;

	// Framing codes.
	localparam logic [7:0] SYNC_CODE = 8'h55;
	localparam logic [7:0] ESC_CODE  = 8'hDD;
	localparam logic [7:0] ESC_FLIP  = 8'h80;

	// Reflected CRC-16/ARC polynomial.
	localparam logic [15:0] CRC_POLY_REFL = 16'hA001;

	// Frame limits.
	localparam int MAX_FRAME    = 1032;
	localparam int HEADER_BYTES = 5;
	localparam int PREFIX_DEPTH = HEADER_BYTES - 1;
	localparam int PREFIX_AW    = $clog2(PREFIX_DEPTH);

	// Field widths.
	localparam int IDX_W = 11;
	localparam int LEN_W = 16;

	// Frame status codes.
	typedef enum logic [1:0] {
		STATUS_BUSY     = 2'd0,
		STATUS_GOOD     = 2'd1,
		STATUS_CRC_ERR  = 2'd2,
		STATUS_TOO_LONG = 2'd3
	} fprc_status_t;

	// One decoded result transaction.
	typedef struct packed {
		logic [7:0]       data_byte;
		logic [IDX_W-1:0] byte_index;
		logic             last;
		fprc_status_t     frame_status;
		logic [LEN_W-1:0] frame_length;
		logic [2:0]       packet_class;
		logic [4:0]       function_code;
		logic [3:0]       channel_id;
		logic [2:0]       sequence_id;
		logic [7:0]       handle_byte;
	} fprc_result_t;

endpackage

[hdl/fprc_crc_byte.sv]
// ----------------------------------------------------------------------------
// fprc_crc_byte
// CRC-16/ARC update by one byte, eight reflected shift steps.
// ----------------------------------------------------------------------------
module fprc_crc_byte import fprc_pkg::*; (
	input  logic [15:0] crc_in,
	input  logic [7:0]  data_in,
	output logic [15:0] crc_out
);

	// Fold the byte in, then shift out eight bits.
	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {8'h00, data_in};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY_REFL;
			end else begin
				c = c >> 1;
			end
		end
		crc_out = c;
	end

endmodule

[hdl/fprc_frame_ctrl.sv]
// ----------------------------------------------------------------------------
// fprc_frame_ctrl
// Frame state: sync and escape handling, header capture, byte count and
// CRC check. Produces the result for the byte that is presented.
// ----------------------------------------------------------------------------
module fprc_frame_ctrl import fprc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [7:0]   rx_byte,
	input  logic         take,
	output logic         has_result,
	output fprc_result_t result
);

	localparam logic [IDX_W-1:0] HDR_LAST = IDX_W'(HEADER_BYTES - 1);
	localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_FRAME);
	localparam logic [LEN_W-1:0] HDR_LEN  = LEN_W'(HEADER_BYTES);

	logic             in_sync_q, esc_q;
	logic [IDX_W-1:0] count_q;
	logic [7:0]       len_lo_q, len_hi_q, type_q, xid_q, handle_q;
	logic [15:0]      crc_q;
	logic [15:0]      prefix_q [PREFIX_DEPTH];

	logic             in_sync_d, esc_d;
	logic [IDX_W-1:0] count_d;
	logic [7:0]       len_lo_d, len_hi_d, type_d, xid_d, handle_d;
	logic [15:0]      crc_d;
	logic             prefix_we;

	logic             is_sync, is_esc, is_data;
	logic [7:0]       ch;
	logic [15:0]      crc_seed, crc_new, crc_chk;
	logic [LEN_W-1:0] len, len_m1;
	logic [IDX_W-1:0] cnt;
	logic             hdr_done, too_long, at_end;
	fprc_status_t     status;
	logic             last;

	// Byte classification.
	assign is_sync = (rx_byte == SYNC_CODE);
	assign is_esc  = (rx_byte == ESC_CODE);
	assign is_data = !is_sync && in_sync_q && !is_esc;
	assign ch      = esc_q ? (rx_byte ^ ESC_FLIP) : rx_byte;

	// CRC update, restarted on the first byte of a frame.
	assign crc_seed = (count_q == '0) ? 16'h0000 : crc_q;

	fprc_crc_byte u_crc (
		.crc_in  (crc_seed),
		.data_in (ch),
		.crc_out (crc_new)
	);

	// Length check once the header is complete.
	assign cnt      = count_q + IDX_W'(1);
	assign len      = {len_hi_q, len_lo_q};
	assign len_m1   = len - LEN_W'(1);
	assign hdr_done = (count_q >= HDR_LAST);
	assign too_long = hdr_done && (len > MAX_LEN);
	assign at_end   = hdr_done && !too_long && (LEN_W'(cnt) >= len);

	// A short frame is checked against the CRC stored after its last byte.
	always_comb begin
		priority if (len >= HDR_LEN) begin
			crc_chk = crc_new;
		end else if (len == '0) begin
			crc_chk = 16'h0000;
		end else begin
			crc_chk = prefix_q[len_m1[PREFIX_AW-1:0]];
		end
	end

	always_comb begin
		priority if (too_long) begin
			status = STATUS_TOO_LONG;
		end else if (!at_end) begin
			status = STATUS_BUSY;
		end else if (crc_chk == 16'h0000) begin
			status = STATUS_GOOD;
		end else begin
			status = STATUS_CRC_ERR;
		end
	end
	assign last = too_long || at_end;

	// Next state.
	always_comb begin
		in_sync_d = in_sync_q;
		esc_d     = esc_q;
		count_d   = count_q;
		len_lo_d  = len_lo_q;
		len_hi_d  = len_hi_q;
		type_d    = type_q;
		xid_d     = xid_q;
		handle_d  = handle_q;
		crc_d     = crc_q;
		prefix_we = 1'b0;
		priority if (is_sync) begin
			in_sync_d = 1'b1;
			esc_d     = 1'b0;
			count_d   = '0;
			len_lo_d  = 8'h00;
			len_hi_d  = 8'h00;
			type_d    = 8'hFF;
			xid_d     = 8'hFF;
		end else if (!in_sync_q) begin
			in_sync_d = 1'b0;
		end else if (is_esc) begin
			esc_d = 1'b1;
		end else begin
			esc_d = 1'b0;
			crc_d = crc_new;
			prefix_we = (count_q < HDR_LAST);
			unique case (count_q)
				IDX_W'(0): len_lo_d = ch;
				IDX_W'(1): len_hi_d = ch;
				IDX_W'(2): type_d   = ch;
				IDX_W'(3): xid_d    = ch;
				IDX_W'(4): handle_d = ch;
				default:   ;
			endcase
			if (too_long) begin
				in_sync_d = 1'b0;
				count_d   = '0;
			end else if (at_end) begin
				count_d   = '0;
				in_sync_d = (status == STATUS_GOOD);
			end else begin
				count_d = cnt;
			end
		end
	end

	// Result of this byte, header fields as they stand after it.
	assign has_result = is_data;
	always_comb begin
		result.data_byte     = ch;
		result.byte_index    = count_q;
		result.last          = last;
		result.frame_status  = status;
		result.frame_length  = hdr_done ? len : '0;
		result.packet_class  = type_d[7:5];
		result.function_code = type_d[4:0];
		result.channel_id    = xid_d[3:0];
		result.sequence_id   = xid_d[6:4];
		result.handle_byte   = handle_d;
	end

	// Frame state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sync_q <= 1'b0;
			esc_q     <= 1'b0;
			count_q   <= '0;
			len_lo_q  <= 8'h00;
			len_hi_q  <= 8'h00;
			type_q    <= 8'hFF;
			xid_q     <= 8'hFF;
			handle_q  <= 8'h00;
			crc_q     <= 16'h0000;
		end else if (take) begin
			in_sync_q <= in_sync_d;
			esc_q     <= esc_d;
			count_q   <= count_d;
			len_lo_q  <= len_lo_d;
			len_hi_q  <= len_hi_d;
			type_q    <= type_d;
			xid_q     <= xid_d;
			handle_q  <= handle_d;
			crc_q     <= crc_d;
		end
	end

	// Running CRC after each of the first four header bytes, for frames shorter than the header.
	always_ff @(posedge clk) begin
		if (take && prefix_we) begin
			prefix_q[count_q[PREFIX_AW-1:0]] <= crc_new;
		end
	end

endmodule

[hdl/framed_packet_receiver_crc16_core.sv]
// ----------------------------------------------------------------------------
// framed_packet_receiver_crc16_core
// Byte-stuffed frame receiver: removes sync and escape codes, numbers the
// decoded bytes, captures the header and checks the CRC-16/ARC of each frame.
//
//   Channel   Direction  Handshake             Payload
//   input     in         in_valid / in_stall   rx_byte
//   output    out        out_valid / out_stall data_byte .. handle_byte
//
// One byte is taken every cycle while in_stall is low; a decoded byte is
// registered in the input register and then in the result register, which
// drives out_valid.
// The combinational path from the input register is the CRC byte update plus the length compare.
// Reset clears the frame state registers, but not the prefix CRC store; the receiver starts out of sync.
// Sync, escape and ignored bytes pass even while the output is stalled;
// a decoded byte waits in the input register until the result register frees.
// ----------------------------------------------------------------------------
module framed_packet_receiver_crc16_core import fprc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       rx_byte,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       data_byte,
	output logic [IDX_W-1:0] byte_index,
	output logic             last,
	output logic [1:0]       frame_status,
	output logic [LEN_W-1:0] frame_length,
	output logic [2:0]       packet_class,
	output logic [4:0]       function_code,
	output logic [3:0]       channel_id,
	output logic [2:0]       sequence_id,
	output logic [7:0]       handle_byte
);

	logic         valid_s1;
	logic [7:0]   rx_byte_s1;
	logic         out_valid_s2;
	fprc_result_t result_s2;

	logic         has_result;
	fprc_result_t result;
	logic         advance, take;

	// Pipeline control.
	assign advance  = !out_valid_s2 || !out_stall;
	assign take     = valid_s1 && (advance || !has_result);
	assign in_stall = valid_s1 && !take;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	// Frame decoding and checking.
	fprc_frame_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_byte    (rx_byte_s1),
		.take       (take),
		.has_result (has_result),
		.result     (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= valid_s1 && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && has_result) begin
			result_s2 <= result;
		end
	end

	// Output ports.
	assign out_valid     = out_valid_s2;
	assign data_byte     = result_s2.data_byte;
	assign byte_index    = result_s2.byte_index;
	assign last          = result_s2.last;
	assign frame_status  = result_s2.frame_status;
	assign frame_length  = result_s2.frame_length;
	assign packet_class  = result_s2.packet_class;
	assign function_code = result_s2.function_code;
	assign channel_id    = result_s2.channel_id;
	assign sequence_id   = result_s2.sequence_id;
	assign handle_byte   = result_s2.handle_byte;

	// A byte that yields no result never holds up the input.
	a_no_result_passes: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !has_result) |-> !in_stall)
		else $error("byte without result stalled the input");

	// A finished or aborted frame is always marked as last.
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (frame_status == STATUS_GOOD || frame_status == STATUS_CRC_ERR
			|| frame_status == STATUS_TOO_LONG)) |-> last)
		else $error("final status without last");

	// A byte in mid frame carries the in-progress status.
	a_last_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> (frame_status == STATUS_BUSY))
		else $error("status set on a byte that is not last");

	// The length is not reported before the header is complete.
	a_len_header: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (byte_index < IDX_W'(HEADER_BYTES - 1))) |-> (frame_length == '0))
		else $error("frame length shown inside the header");

endmodule
